>>> rtl/i2cmw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master write engine package
// Shared types and constants for the write engine, its queues and top level.
// ----------------------------------------------------------------------------
package i2cmw_pkg;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_ADDRESS_BYTE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_TICKS  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ACK_TRIES    = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [7:0] ADDRESS_BYTE_RST = 8'd120;
    localparam logic [7:0] PHASE_TICKS_RST  = 8'd100;
    localparam logic [7:0] ACK_TRIES_RST    = 8'd19;

    // Bus phases of the engine.
    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_ST_HIGH  = 4'd1,
        PH_ST_SDA0  = 4'd2,
        PH_ST_SCL0  = 4'd3,
        PH_WAIT     = 4'd4,
        PH_BIT_LOW  = 4'd5,
        PH_BIT_HIGH = 4'd6,
        PH_ACK_REL  = 4'd7,
        PH_ACK_POLL = 4'd8,
        PH_ACK_END  = 4'd9,
        PH_SP_A     = 4'd10,
        PH_SP_B     = 4'd11,
        PH_SP_C     = 4'd12
    } phase_t;

    // Which byte of the transaction is on the wire.
    typedef enum logic [1:0] {
        STAGE_ADDR  = 2'd0,
        STAGE_CTRL  = 2'd1,
        STAGE_DATA  = 2'd2,
        STAGE_ABORT = 2'd3
    } stage_t;

    // One tick request.
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic       sda_sample;
    } item_t;

    // One tick result.
    typedef struct packed {
        logic scl_level;
        logic sda_level;
        logic sda_drive;
        logic byte_taken;
        logic busy_res;
        logic done_res;
        logic nack_error;
    } result_t;

    // Configuration write request.
    typedef struct packed {
        logic                  we;
        logic [CFG_ADDR_W-1:0] addr;
        logic [7:0]            wdata;
    } cfg_wr_t;

endpackage

>>> rtl/i2c_master_write_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master write engine
// Tick-driven I2C write sequencer with queued requests and results.
// ----------------------------------------------------------------------------
// Usage:
// Each request is one bus time tick carrying the sampled SDA level and an
// optional byte offer. Requests enter through push/full; a request is taken
// on a clock edge with push high and full low. Results (SCL/SDA levels, SDA
// drive, byte_taken, busy, done and NACK error) leave through empty/pop, one
// result per request, in order.
// The sequencer takes a request from the head of the request queue and writes
// its result into the result queue at the same edge, once that queue has room.
// It handles one request per cycle while the result queue has room, and the
// queues take a push and a pop in the same cycle.
// When pop stays low the result queue fills, the sequencer halts, and then
// the request queue fills and raises full. No request or result is lost.
// Reset clears both queues, puts the bus in idle with both lines high and
// loads the register defaults (address 120, phase 100 ticks, 19 ACK polls).
// Configuration writes through cfg_we/cfg_addr/cfg_wdata take effect at once
// and belong to quiet periods between transactions.
// ----------------------------------------------------------------------------
module i2c_master_write_engine_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    // Configuration write port
    input  logic       cfg_we,
    input  logic [1:0] cfg_addr,
    input  logic [7:0] cfg_wdata,
    // Request side
    input  logic       push,
    output logic       full,
    input  logic       byte_valid,
    input  logic [7:0] data_byte,
    input  logic       first_byte,
    input  logic       last_byte,
    input  logic       sda_sample,
    // Result side
    output logic       empty,
    input  logic       pop,
    output logic       scl_level,
    output logic       sda_level,
    output logic       sda_drive,
    output logic       byte_taken,
    output logic       busy_res,
    output logic       done_res,
    output logic       nack_error
);

    i2cmw_pkg::item_t   in_item;
    i2cmw_pkg::item_t   q_item;
    i2cmw_pkg::result_t eng_res;
    i2cmw_pkg::result_t out_res;
    i2cmw_pkg::cfg_wr_t cfg;
    logic               q_empty;
    logic               q_pop;
    logic               res_push;
    logic               res_full;

    // Pack the request fields and the configuration write.
    assign in_item.byte_valid = byte_valid;
    assign in_item.data_byte  = data_byte;
    assign in_item.first_byte = first_byte;
    assign in_item.last_byte  = last_byte;
    assign in_item.sda_sample = sda_sample;
    assign cfg.we             = cfg_we;
    assign cfg.addr           = cfg_addr;
    assign cfg.wdata          = cfg_wdata;

    // Front: request queue.
    i2cmw_fifo #(
        .WIDTH ($bits(i2cmw_pkg::item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_req_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (in_item),
        .full  (full),
        .pop   (q_pop),
        .rdata (q_item),
        .empty (q_empty)
    );

    // Middle: bus sequencer.
    i2cmw_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item       (q_item),
        .item_valid (!q_empty),
        .item_pop   (q_pop),
        .res        (eng_res),
        .res_push   (res_push),
        .res_full   (res_full)
    );

    // Result queue.
    i2cmw_fifo #(
        .WIDTH ($bits(i2cmw_pkg::result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (eng_res),
        .full  (res_full),
        .pop   (pop),
        .rdata (out_res),
        .empty (empty)
    );

    // Unpack the result fields.
    assign scl_level  = out_res.scl_level;
    assign sda_level  = out_res.sda_level;
    assign sda_drive  = out_res.sda_drive;
    assign byte_taken = out_res.byte_taken;
    assign busy_res   = out_res.busy_res;
    assign done_res   = out_res.done_res;
    assign nack_error = out_res.nack_error;

endmodule

>>> rtl/i2cmw_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C write engine queue
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module i2cmw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    // Status and handshake qualification.
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = store_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on a lone push");

    assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not shrink on a lone pop");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CNT_W'(DEPTH)))
        else $error("queue count beyond depth");

endmodule

>>> rtl/i2cmw_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C write engine bus sequencer, holding the configuration registers
// Runs one bus tick per cycle while a tick is queued and results have room.
// ----------------------------------------------------------------------------
module i2cmw_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  i2cmw_pkg::cfg_wr_t cfg,
    input  i2cmw_pkg::item_t   item,
    input  logic               item_valid,
    output logic               item_pop,
    output i2cmw_pkg::result_t res,
    output logic               res_push,
    input  logic               res_full
);

    logic [7:0]          address_byte_reg;
    logic [7:0]          phase_ticks_reg;
    logic [7:0]          ack_tries_reg;

    i2cmw_pkg::phase_t   phase_reg;
    i2cmw_pkg::phase_t   phase_next;
    logic [7:0]          tick_reg;
    logic [7:0]          tick_next;
    logic [2:0]          bit_reg;
    logic [2:0]          bit_next;
    logic [7:0]          shift_reg;
    logic [7:0]          shift_next;
    logic [7:0]          poll_reg;
    logic [7:0]          poll_next;
    i2cmw_pkg::stage_t   stage_reg;
    i2cmw_pkg::stage_t   stage_next;
    logic                ending_reg;
    logic                ending_next;
    logic                dropping_reg;
    logic                dropping_next;

    logic                step_en;
    logic                timed;
    logic [7:0]          span;
    logic [7:0]          tries;
    logic [7:0]          poll_inc;
    logic                phase_done;

    // A tick runs when one is queued and the result queue has room.
    assign step_en  = item_valid && !res_full;
    assign item_pop = step_en;
    assign res_push = step_en;

    // A zero phase length or poll count behaves as one.
    assign span       = (phase_ticks_reg == 8'd0) ? 8'd1 : phase_ticks_reg;
    assign tries      = (ack_tries_reg == 8'd0) ? 8'd1 : ack_tries_reg;
    assign poll_inc   = poll_reg + 8'd1;
    assign phase_done = ({1'b0, tick_reg} + 9'd1) >= {1'b0, span};

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_byte_reg <= i2cmw_pkg::ADDRESS_BYTE_RST;
            phase_ticks_reg  <= i2cmw_pkg::PHASE_TICKS_RST;
            ack_tries_reg    <= i2cmw_pkg::ACK_TRIES_RST;
        end
        else if (cfg.we)
        begin
            unique case (cfg.addr)
                i2cmw_pkg::REG_ADDRESS_BYTE: address_byte_reg <= cfg.wdata;
                i2cmw_pkg::REG_PHASE_TICKS:  phase_ticks_reg  <= cfg.wdata;
                i2cmw_pkg::REG_ACK_TRIES:    ack_tries_reg    <= cfg.wdata;
                default: ;
            endcase
        end
    end

    // Line levels of the current phase and the move to the next one.
    always_comb
    begin
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        bit_next      = bit_reg;
        shift_next    = shift_reg;
        poll_next     = poll_reg;
        stage_next    = stage_reg;
        ending_next   = ending_reg;
        dropping_next = dropping_reg;
        timed         = 1'b1;
        res           = '0;
        res.sda_level = 1'b1;
        res.sda_drive = 1'b1;
        res.busy_res  = 1'b1;

        unique case (phase_reg)
            i2cmw_pkg::PH_IDLE:
            begin
                timed         = 1'b0;
                res.scl_level = 1'b1;
                res.busy_res  = 1'b0;
                if (item.byte_valid)
                begin
                    if (dropping_reg)
                    begin
                        res.byte_taken = 1'b1;
                        if (item.last_byte)
                        begin
                            dropping_next = 1'b0;
                        end
                    end
                    else if (item.first_byte)
                    begin
                        shift_next  = address_byte_reg;
                        stage_next  = i2cmw_pkg::STAGE_ADDR;
                        ending_next = 1'b0;
                        bit_next    = '0;
                        poll_next   = '0;
                        tick_next   = '0;
                        phase_next  = i2cmw_pkg::PH_ST_HIGH;
                    end
                    else
                    begin
                        res.byte_taken = 1'b1;
                    end
                end
            end
            i2cmw_pkg::PH_WAIT:
            begin
                timed = 1'b0;
                if (item.byte_valid)
                begin
                    res.byte_taken = 1'b1;
                    shift_next     = item.data_byte;
                    ending_next    = item.last_byte;
                    stage_next     = (stage_reg == i2cmw_pkg::STAGE_ADDR) ?
                                     i2cmw_pkg::STAGE_CTRL : i2cmw_pkg::STAGE_DATA;
                    bit_next       = '0;
                    tick_next      = '0;
                    phase_next     = i2cmw_pkg::PH_BIT_LOW;
                end
            end
            i2cmw_pkg::PH_ST_HIGH:
            begin
                res.scl_level = 1'b1;
            end
            i2cmw_pkg::PH_ST_SDA0:
            begin
                res.scl_level = 1'b1;
                res.sda_level = 1'b0;
            end
            i2cmw_pkg::PH_ST_SCL0:
            begin
                res.sda_level = 1'b0;
            end
            i2cmw_pkg::PH_BIT_LOW:
            begin
                res.sda_level = shift_reg[7];
            end
            i2cmw_pkg::PH_BIT_HIGH:
            begin
                res.scl_level = 1'b1;
                res.sda_level = shift_reg[7];
            end
            i2cmw_pkg::PH_ACK_REL:
            begin
                res.sda_drive = 1'b0;
            end
            i2cmw_pkg::PH_ACK_POLL:
            begin
                res.scl_level = 1'b1;
                res.sda_drive = 1'b0;
            end
            i2cmw_pkg::PH_ACK_END: ;
            i2cmw_pkg::PH_SP_A:
            begin
                res.sda_level = 1'b0;
            end
            i2cmw_pkg::PH_SP_B:
            begin
                res.scl_level = 1'b1;
                res.sda_level = 1'b0;
            end
            default:
            begin
                res.scl_level = 1'b1;
            end
        endcase

        // Timed phases count ticks and advance at the end of the span.
        if (timed)
        begin
            if (phase_done)
            begin
                tick_next = '0;
                unique case (phase_reg)
                    i2cmw_pkg::PH_ST_HIGH: phase_next = i2cmw_pkg::PH_ST_SDA0;
                    i2cmw_pkg::PH_ST_SDA0: phase_next = i2cmw_pkg::PH_ST_SCL0;
                    i2cmw_pkg::PH_ST_SCL0: phase_next = i2cmw_pkg::PH_BIT_LOW;
                    i2cmw_pkg::PH_BIT_LOW: phase_next = i2cmw_pkg::PH_BIT_HIGH;
                    i2cmw_pkg::PH_BIT_HIGH:
                    begin
                        shift_next = {shift_reg[6:0], 1'b0};
                        if (bit_reg == 3'd7)
                        begin
                            bit_next   = '0;
                            phase_next = i2cmw_pkg::PH_ACK_REL;
                        end
                        else
                        begin
                            bit_next   = bit_reg + 3'd1;
                            phase_next = i2cmw_pkg::PH_BIT_LOW;
                        end
                    end
                    i2cmw_pkg::PH_ACK_REL:
                    begin
                        poll_next  = '0;
                        phase_next = i2cmw_pkg::PH_ACK_POLL;
                    end
                    i2cmw_pkg::PH_ACK_POLL:
                    begin
                        if (!item.sda_sample)
                        begin
                            phase_next = i2cmw_pkg::PH_ACK_END;
                        end
                        else
                        begin
                            poll_next = poll_inc;
                            if (poll_inc >= tries)
                            begin
                                stage_next    = i2cmw_pkg::STAGE_ABORT;
                                dropping_next = !ending_reg;
                                phase_next    = i2cmw_pkg::PH_ACK_END;
                            end
                        end
                    end
                    i2cmw_pkg::PH_ACK_END:
                    begin
                        poll_next = '0;
                        if (stage_reg == i2cmw_pkg::STAGE_ABORT || ending_reg)
                        begin
                            phase_next = i2cmw_pkg::PH_SP_A;
                        end
                        else
                        begin
                            phase_next = i2cmw_pkg::PH_WAIT;
                        end
                    end
                    i2cmw_pkg::PH_SP_A: phase_next = i2cmw_pkg::PH_SP_B;
                    i2cmw_pkg::PH_SP_B: phase_next = i2cmw_pkg::PH_SP_C;
                    default:
                    begin
                        // Stop complete: report and return to idle.
                        phase_next     = i2cmw_pkg::PH_IDLE;
                        res.done_res   = 1'b1;
                        res.nack_error = (stage_reg == i2cmw_pkg::STAGE_ABORT);
                        stage_next     = i2cmw_pkg::STAGE_ADDR;
                        ending_next    = 1'b0;
                        bit_next       = '0;
                        poll_next      = '0;
                    end
                endcase
            end
            else
            begin
                tick_next = tick_reg + 8'd1;
            end
        end
    end

    // Sequencer state, updated once per tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= i2cmw_pkg::PH_IDLE;
            tick_reg     <= '0;
            bit_reg      <= '0;
            shift_reg    <= '0;
            poll_reg     <= '0;
            stage_reg    <= i2cmw_pkg::STAGE_ADDR;
            ending_reg   <= 1'b0;
            dropping_reg <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            bit_reg      <= bit_next;
            shift_reg    <= shift_next;
            poll_reg     <= poll_next;
            stage_reg    <= stage_next;
            ending_reg   <= ending_next;
            dropping_reg <= dropping_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && res.done_res) |=> (phase_reg == i2cmw_pkg::PH_IDLE))
        else $error("stop completed but engine did not return to idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && res.byte_taken) |->
        (phase_reg == i2cmw_pkg::PH_IDLE || phase_reg == i2cmw_pkg::PH_WAIT))
        else $error("byte taken outside idle or wait phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!res.sda_drive) |->
        (phase_reg == i2cmw_pkg::PH_ACK_REL || phase_reg == i2cmw_pkg::PH_ACK_POLL))
        else $error("SDA released outside the acknowledge slot");

    assert property (@(posedge clk) disable iff (!rst_n)
        res.nack_error |-> (res.done_res && stage_reg == i2cmw_pkg::STAGE_ABORT))
        else $error("NACK error reported without an aborted stop");

endmodule

>>> bench/i2c_write_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C write engine line checker
// Runs every accepted tick request through its own model of the bus
// sequencer and compares each popped result with the expected line state.
// ----------------------------------------------------------------------------
module i2c_write_checker (
    input  logic       clk,
    input  logic       rst_n,
    // Configuration writes, watched to keep the model's registers current
    input  logic       cfg_we,
    input  logic [1:0] cfg_addr,
    input  logic [7:0] cfg_wdata,
    // Request side
    input  logic       push,
    input  logic       full,
    input  logic       byte_valid,
    input  logic [7:0] data_byte,
    input  logic       first_byte,
    input  logic       last_byte,
    input  logic       sda_sample,
    // Result side
    input  logic       empty,
    input  logic       pop,
    input  logic       scl_level,
    input  logic       sda_level,
    input  logic       sda_drive,
    input  logic       byte_taken,
    input  logic       busy_res,
    input  logic       done_res,
    input  logic       nack_error,
    // Status handed to the stimulus side
    output int         fail_count,
    output int         pending,
    output int         checked_count,
    output int         stop_count,
    output int         nack_count,
    output logic       byte_consumed,
    output logic       bus_idle
);

    // Model copy of the configuration registers.
    logic [7:0] addr_reg;
    logic [7:0] phase_reg;
    logic [7:0] tries_reg;

    // Model copy of the sequencer state.
    i2cmw_pkg::phase_t line_phase;
    logic [7:0]        tick_cnt;
    logic [2:0]        bit_idx;
    logic [7:0]        shreg;
    logic [7:0]        polls;
    i2cmw_pkg::stage_t stage;
    logic              ending;
    logic              dropping;

    // Expected line states, oldest first.
    i2cmw_pkg::result_t expected_lines[$];

    // Moves the bus to its next phase once the current one has run out.
    // Returns 1 when a stop condition completes.
    function automatic logic end_of_phase(input logic sda);
        logic [7:0] tries;
        tries = (tries_reg == 8'd0) ? 8'd1 : tries_reg;
        end_of_phase = 1'b0;
        case (line_phase)
            i2cmw_pkg::PH_ST_HIGH:  line_phase = i2cmw_pkg::PH_ST_SDA0;
            i2cmw_pkg::PH_ST_SDA0:  line_phase = i2cmw_pkg::PH_ST_SCL0;
            i2cmw_pkg::PH_ST_SCL0:  line_phase = i2cmw_pkg::PH_BIT_LOW;
            i2cmw_pkg::PH_BIT_LOW:  line_phase = i2cmw_pkg::PH_BIT_HIGH;
            i2cmw_pkg::PH_BIT_HIGH:
            begin
                shreg = {shreg[6:0], 1'b0};
                if (bit_idx == 3'd7)
                begin
                    bit_idx = 3'd0;
                    line_phase = i2cmw_pkg::PH_ACK_REL;
                end
                else
                begin
                    bit_idx = bit_idx + 3'd1;
                    line_phase = i2cmw_pkg::PH_BIT_LOW;
                end
            end
            i2cmw_pkg::PH_ACK_REL:
            begin
                polls = 8'd0;
                line_phase = i2cmw_pkg::PH_ACK_POLL;
            end
            i2cmw_pkg::PH_ACK_POLL:
            begin
                if (!sda)
                    line_phase = i2cmw_pkg::PH_ACK_END;
                else
                begin
                    polls = polls + 8'd1;
                    if (polls >= tries)
                    begin
                        // Out of polls: the slave did not acknowledge.
                        stage = i2cmw_pkg::STAGE_ABORT;
                        dropping = !ending;
                        line_phase = i2cmw_pkg::PH_ACK_END;
                    end
                end
            end
            i2cmw_pkg::PH_ACK_END:
            begin
                polls = 8'd0;
                if (stage == i2cmw_pkg::STAGE_ABORT || ending)
                    line_phase = i2cmw_pkg::PH_SP_A;
                else
                    line_phase = i2cmw_pkg::PH_WAIT;
            end
            i2cmw_pkg::PH_SP_A:     line_phase = i2cmw_pkg::PH_SP_B;
            i2cmw_pkg::PH_SP_B:     line_phase = i2cmw_pkg::PH_SP_C;
            default:
            begin
                line_phase = i2cmw_pkg::PH_IDLE;
                end_of_phase = 1'b1;
            end
        endcase
    endfunction

    // Works out the line state shown during one tick and advances the model.
    function automatic i2cmw_pkg::result_t predict_tick(input i2cmw_pkg::item_t req);
        i2cmw_pkg::result_t res;
        logic               timed;
        logic               cur_bit;
        logic               aborted;
        logic [7:0]         span;
        res = '0;
        res.sda_level = 1'b1;
        res.sda_drive = 1'b1;
        res.busy_res = 1'b1;
        timed = 1'b1;
        cur_bit = shreg[7];
        span = (phase_reg == 8'd0) ? 8'd1 : phase_reg;
        if (line_phase > i2cmw_pkg::PH_SP_C)
            line_phase = i2cmw_pkg::PH_IDLE;

        case (line_phase)
            i2cmw_pkg::PH_IDLE:
            begin
                timed = 1'b0;
                res.scl_level = 1'b1;
                res.busy_res = 1'b0;
                if (req.byte_valid)
                begin
                    if (dropping)
                    begin
                        // Leftovers of an aborted transfer are swallowed.
                        res.byte_taken = 1'b1;
                        if (req.last_byte)
                            dropping = 1'b0;
                    end
                    else if (req.first_byte)
                    begin
                        // Open a transfer; the byte itself waits for the address.
                        shreg = addr_reg;
                        stage = i2cmw_pkg::STAGE_ADDR;
                        ending = 1'b0;
                        bit_idx = 3'd0;
                        polls = 8'd0;
                        tick_cnt = 8'd0;
                        line_phase = i2cmw_pkg::PH_ST_HIGH;
                    end
                    else
                        res.byte_taken = 1'b1;
                end
            end
            i2cmw_pkg::PH_WAIT:
            begin
                timed = 1'b0;
                if (req.byte_valid)
                begin
                    res.byte_taken = 1'b1;
                    shreg = req.data_byte;
                    ending = req.last_byte;
                    stage = (stage == i2cmw_pkg::STAGE_ADDR) ?
                            i2cmw_pkg::STAGE_CTRL : i2cmw_pkg::STAGE_DATA;
                    bit_idx = 3'd0;
                    tick_cnt = 8'd0;
                    line_phase = i2cmw_pkg::PH_BIT_LOW;
                end
            end
            i2cmw_pkg::PH_ST_HIGH:
                res.scl_level = 1'b1;
            i2cmw_pkg::PH_ST_SDA0:
            begin
                res.scl_level = 1'b1;
                res.sda_level = 1'b0;
            end
            i2cmw_pkg::PH_ST_SCL0:
                res.sda_level = 1'b0;
            i2cmw_pkg::PH_BIT_LOW:
                res.sda_level = cur_bit;
            i2cmw_pkg::PH_BIT_HIGH:
            begin
                res.scl_level = 1'b1;
                res.sda_level = cur_bit;
            end
            i2cmw_pkg::PH_ACK_REL:
                res.sda_drive = 1'b0;
            i2cmw_pkg::PH_ACK_POLL:
            begin
                res.scl_level = 1'b1;
                res.sda_drive = 1'b0;
            end
            i2cmw_pkg::PH_ACK_END:
                res.scl_level = 1'b0;
            i2cmw_pkg::PH_SP_A:
                res.sda_level = 1'b0;
            i2cmw_pkg::PH_SP_B:
            begin
                res.scl_level = 1'b1;
                res.sda_level = 1'b0;
            end
            default:
                res.scl_level = 1'b1;
        endcase

        // Timed phases count ticks and step on when the phase runs out.
        if (timed)
        begin
            if ({1'b0, tick_cnt} + 9'd1 >= {1'b0, span})
            begin
                aborted = (stage == i2cmw_pkg::STAGE_ABORT);
                tick_cnt = 8'd0;
                if (end_of_phase(req.sda_sample))
                begin
                    res.done_res = 1'b1;
                    res.nack_error = aborted;
                    stage = i2cmw_pkg::STAGE_ADDR;
                    ending = 1'b0;
                    bit_idx = 3'd0;
                    polls = 8'd0;
                end
            end
            else
                tick_cnt = tick_cnt + 8'd1;
        end
        return res;
    endfunction

    // Reports one field that differs from its expected value.
    function automatic int field_miss(input string field, input logic want, input logic got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %b, got %b", field, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Track requests and results at every rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        i2cmw_pkg::result_t want;
        int                 miss;
        int                 stops;
        int                 nacks;
        int                 checks;
        if (!rst_n)
        begin
            addr_reg = i2cmw_pkg::ADDRESS_BYTE_RST;
            phase_reg = i2cmw_pkg::PHASE_TICKS_RST;
            tries_reg = i2cmw_pkg::ACK_TRIES_RST;
            line_phase = i2cmw_pkg::PH_IDLE;
            tick_cnt = 8'd0;
            bit_idx = 3'd0;
            shreg = 8'd0;
            polls = 8'd0;
            stage = i2cmw_pkg::STAGE_ADDR;
            ending = 1'b0;
            dropping = 1'b0;
            expected_lines.delete();
            fail_count <= 0;
            pending <= 0;
            checked_count <= 0;
            stop_count <= 0;
            nack_count <= 0;
            byte_consumed <= 1'b0;
            bus_idle <= 1'b1;
        end
        else
        begin
            miss = 0;
            stops = 0;
            nacks = 0;
            checks = 0;

            // Register writes only happen while nothing is in flight.
            if (cfg_we)
            begin
                case (cfg_addr)
                    i2cmw_pkg::REG_ADDRESS_BYTE: addr_reg = cfg_wdata;
                    i2cmw_pkg::REG_PHASE_TICKS:  phase_reg = cfg_wdata;
                    i2cmw_pkg::REG_ACK_TRIES:    tries_reg = cfg_wdata;
                    default: ;
                endcase
            end

            // A popped result is held against the oldest expectation.
            if (pop && !empty)
            begin
                checks = 1;
                if (expected_lines.size() == 0)
                begin
                    $error("result popped while no result was expected");
                    miss = 1;
                end
                else
                begin
                    want = expected_lines.pop_front();
                    miss += field_miss("scl_level", want.scl_level, scl_level);
                    miss += field_miss("sda_level", want.sda_level, sda_level);
                    miss += field_miss("sda_drive", want.sda_drive, sda_drive);
                    miss += field_miss("byte_taken", want.byte_taken, byte_taken);
                    miss += field_miss("busy_res", want.busy_res, busy_res);
                    miss += field_miss("done_res", want.done_res, done_res);
                    miss += field_miss("nack_error", want.nack_error, nack_error);
                end
            end

            // An accepted request adds one expected result.
            if (push && !full)
            begin
                want = predict_tick('{byte_valid, data_byte, first_byte, last_byte,
                                      sda_sample});
                expected_lines.push_back(want);
                stops = want.done_res;
                nacks = want.done_res & want.nack_error;
                byte_consumed <= want.byte_taken;
                bus_idle <= (line_phase == i2cmw_pkg::PH_IDLE);
            end

            fail_count <= fail_count + miss;
            checked_count <= checked_count + checks;
            stop_count <= stop_count + stops;
            nack_count <= nack_count + nacks;
            pending <= expected_lines.size();
        end
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master write engine regression
// Drives bus ticks carrying whole write transfers, NACKs and stray bytes into
// the engine under several register settings and random queue back-pressure;
// the line checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RANDOM_TICKS = 700;
    localparam int QUIET_LIMIT  = 1000;
    localparam int SETTLE_GAP   = 4;

    // Where a transfer is meant to run into a missing acknowledge.
    typedef enum int {
        NACK_NONE,
        NACK_ON_ADDRESS,
        NACK_ON_LAST
    } nack_plan_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_addr;
    logic [7:0] cfg_wdata;
    logic       push;
    logic       full;
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic       sda_sample;
    logic       empty;
    logic       pop;
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       byte_taken;
    logic       busy_res;
    logic       done_res;
    logic       nack_error;

    int         fail_count;
    int         pending;
    int         checked_count;
    int         stop_count;
    int         nack_count;
    logic       byte_consumed;
    logic       bus_idle;

    int         send_idle_pct;
    int         recv_idle_pct;
    int         ticks_sent;
    int         transfers;
    int         settings;
    int         quiet;

    i2c_master_write_engine_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .push       (push),
        .full       (full),
        .byte_valid (byte_valid),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .sda_sample (sda_sample),
        .empty      (empty),
        .pop        (pop),
        .scl_level  (scl_level),
        .sda_level  (sda_level),
        .sda_drive  (sda_drive),
        .byte_taken (byte_taken),
        .busy_res   (busy_res),
        .done_res   (done_res),
        .nack_error (nack_error)
    );

    i2c_write_checker line_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .push          (push),
        .full          (full),
        .byte_valid    (byte_valid),
        .data_byte     (data_byte),
        .first_byte    (first_byte),
        .last_byte     (last_byte),
        .sda_sample    (sda_sample),
        .empty         (empty),
        .pop           (pop),
        .scl_level     (scl_level),
        .sda_level     (sda_level),
        .sda_drive     (sda_drive),
        .byte_taken    (byte_taken),
        .busy_res      (busy_res),
        .done_res      (done_res),
        .nack_error    (nack_error),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count),
        .stop_count    (stop_count),
        .nack_count    (nack_count),
        .byte_consumed (byte_consumed),
        .bus_idle      (bus_idle)
    );

    // 12 ns clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Result side: pop at random, or always when idling is off.
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog: too long without any request or result moving ends the run.
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet <= 0;
        else
        begin
            if ((push && !full) || (pop && !empty))
                quiet <= 0;
            else if (quiet >= QUIET_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    // SDA as the slave leaves it: held high, or mostly pulled low.
    function automatic logic line_sda(input logic held_high);
        return held_high || ($urandom_range(0, 99) < 15);
    endfunction

    // Pushes one tick request and returns at the falling edge after it is taken.
    task automatic send_tick(input logic valid, input logic [7:0] data,
                             input logic first, input logic last, input logic sda);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        byte_valid <= valid;
        data_byte <= data;
        first_byte <= first;
        last_byte <= last;
        sda_sample <= sda;
        while (full)
            @(negedge clk);
        @(negedge clk);
        ticks_sent++;
    endtask

    // Offers a run of bytes, each held until the engine takes it, then lets
    // the bus tick on until it is back in idle. A fixed pattern below zero
    // means random data.
    task automatic run_transfer(input int n_bytes, input logic opens,
                                input nack_plan_t plan, input int pattern);
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       valid;
        logic       held_high;
        int         i;
        held_high = (plan == NACK_ON_ADDRESS);
        for (i = 0; i < n_bytes; i++)
        begin
            data = (pattern < 0) ? 8'($urandom_range(0, 255)) : 8'(pattern);
            first = (i == 0) ? opens : 1'($urandom_range(0, 1));
            last = (i == n_bytes - 1);
            do
            begin
                valid = ($urandom_range(0, 7) != 0);
                if (valid)
                    send_tick(1'b1, data, first, last, line_sda(held_high));
                else
                    send_tick(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), line_sda(held_high));
            end
            while (!(valid && byte_consumed));
        end

        // The last byte is on the wire now; a NACK on it needs SDA left high.
        if (plan == NACK_ON_LAST)
            held_high = 1'b1;
        while (!bus_idle)
            send_tick(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), line_sda(held_high));
        transfers++;
    endtask

    // Puts one register value on the configuration port.
    task automatic put_reg(input logic [1:0] idx, input logic [7:0] value);
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(negedge clk);
    endtask

    // Waits until the engine has drained, then loads all three registers.
    task automatic apply_setting(input logic [7:0] address, input logic [7:0] phase,
                                 input logic [7:0] tries);
        push <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_GAP) @(negedge clk);
        cfg_we <= 1'b1;
        put_reg(i2cmw_pkg::REG_ADDRESS_BYTE, address);
        put_reg(i2cmw_pkg::REG_PHASE_TICKS, phase);
        put_reg(i2cmw_pkg::REG_ACK_TRIES, tries);
        cfg_we <= 1'b0;
        settings++;
    endtask

    // Picks a random register setting, mostly with short bus phases.
    task automatic random_setting();
        logic [7:0] phase;
        logic [7:0] tries;
        int         pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            phase = 8'd1;
        else if (pick < 8)
            phase = 8'd2;
        else
            phase = 8'($urandom_range(0, 5));
        pick = $urandom_range(0, 9);
        if (pick == 0)
            tries = 8'd0;
        else if (pick < 5)
            tries = 8'd1;
        else if (pick < 8)
            tries = 8'($urandom_range(2, 4));
        else if (pick == 8)
            tries = 8'($urandom_range(5, 30));
        else
            tries = 8'd255;
        apply_setting(8'($urandom_range(0, 255)), phase, tries);
    endtask

    initial
    begin
        nack_plan_t plan;
        int         pick;
        int         start_ticks;
        int         done_ticks;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = i2cmw_pkg::REG_ADDRESS_BYTE;
        cfg_wdata = 8'd0;
        push = 1'b0;
        byte_valid = 1'b0;
        data_byte = 8'd0;
        first_byte = 1'b0;
        last_byte = 1'b0;
        sda_sample = 1'b1;
        ticks_sent = 0;
        transfers = 0;
        settings = 0;
        send_idle_pct = 20;
        recv_idle_pct = 48;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Register defaults: a stray byte while idle.
        run_transfer(1, 1'b0, NACK_NONE, 8'h00);

        // Default address and poll count, with the phase cut to one tick.
        push <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_GAP) @(negedge clk);
        cfg_we <= 1'b1;
        put_reg(i2cmw_pkg::REG_PHASE_TICKS, 8'd1);
        cfg_we <= 1'b0;
        run_transfer(1, 1'b1, NACK_NONE, 8'hFF);

        // Fastest timing, single poll: plain transfer, NACK on the address
        // with the rest dropped, NACK on the closing byte, and a repeated
        // first flag inside a transfer.
        apply_setting(8'h00, 8'd1, 8'd1);
        run_transfer(2, 1'b1, NACK_NONE, 8'h00);
        run_transfer(4, 1'b1, NACK_ON_ADDRESS, -1);
        run_transfer(3, 1'b1, NACK_ON_LAST, 8'hFF);
        run_transfer(4, 1'b1, NACK_NONE, -1);

        // Zero phase length and zero poll count both behave as one.
        apply_setting(8'hFF, 8'd0, 8'd0);
        run_transfer(2, 1'b1, NACK_NONE, -1);
        run_transfer(2, 1'b1, NACK_ON_ADDRESS, -1);

        // Longest poll window, then a longer phase.
        apply_setting(8'h5A, 8'd1, 8'd255);
        run_transfer(2, 1'b1, NACK_ON_ADDRESS, -1);
        run_transfer(2, 1'b1, NACK_NONE, -1);
        apply_setting(8'hC3, 8'd8, 8'd2);
        run_transfer(1, 1'b1, NACK_NONE, -1);

        // Random transfers under changing settings and back-pressure.
        start_ticks = ticks_sent;
        done_ticks = 0;
        while (done_ticks < RANDOM_TICKS)
        begin
            random_setting();
            repeat ($urandom_range(2, 5))
            begin
                done_ticks = ticks_sent - start_ticks;
                if (done_ticks >= 2 * RANDOM_TICKS / 3)
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                else if (done_ticks >= RANDOM_TICKS / 3)
                begin
                    send_idle_pct = 48;
                    recv_idle_pct = 20;
                end
                pick = $urandom_range(0, 19);
                if (pick < 2)
                    plan = NACK_ON_ADDRESS;
                else if (pick < 4)
                    plan = NACK_ON_LAST;
                else
                    plan = NACK_NONE;
                run_transfer($urandom_range(1, 4), ($urandom_range(0, 9) != 0), plan, -1);
            end
            done_ticks = ticks_sent - start_ticks;
        end

        // Drain the result queue and let the pipeline settle.
        push <= 1'b0;
        recv_idle_pct = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("Drove %0d bus ticks in %0d transfers over %0d register settings.",
                 ticks_sent, transfers, settings);
        $display("Compared %0d results covering %0d stop conditions, %0d after a NACK.",
                 checked_count, stop_count, nack_count);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
rtl/i2cmw_pkg.sv
rtl/i2cmw_fifo.sv
rtl/i2cmw_engine.sv
rtl/i2c_master_write_engine_unit.sv
bench/i2c_write_checker.sv
bench/testbench.sv
